[rtl/bsw_pkg.sv]
// Package for the BCD stopwatch with alarms: command codes, time and command
// types, and the two-digit BCD increment used by the tick logic in bsw_clock.
// No dependencies; bsw_clock, bsw_alarms, the top level and the testbench import it.
`default_nettype none

package bsw_pkg;

    // Default size of the alarm table.
    localparam int DEFAULT_NUM_ALARMS = 4;

    // BCD constants.
    localparam logic [3:0] BCD_NINE     = 4'h9;
    localparam logic [6:0] BCD_ADJUST   = 7'h06;
    localparam logic [6:0] BCD_WRAP     = 7'h59;
    localparam logic [3:0] DIGIT_MASK   = 4'hF;

    // Number of alarm bits shown in the status masks.
    localparam int MASK_WIDTH = 4;

    typedef enum logic [2:0] {
        OP_TICK       = 3'd0,
        OP_RESET_TIME = 3'd1,
        OP_PAUSE      = 3'd2,
        OP_EDIT       = 3'd3,
        OP_ENABLE     = 3'd4,
        OP_DISABLE    = 3'd5,
        OP_STOP       = 3'd6
    } op_t;

    // Time as BCD minutes, seconds and tenths; the packed order matches the
    // order in which times compare.
    typedef struct packed {
        logic [6:0] minutes;
        logic [6:0] seconds;
        logic [3:0] tenths;
    } time_t;

    typedef struct packed {
        op_t        op;
        logic [1:0] index;
        time_t      alarm;
    } cmd_t;

    // Two-digit BCD increment with wrap after 59. Bit 7 of the result is the
    // carry out, bits 6:0 the new value. Digits above nine are not fixed up.
    function automatic logic [7:0] bcd2_step(input logic [6:0] v);
        logic [6:0] sum;
        sum = v;
        if (v >= BCD_WRAP) begin
            return {1'b1, 7'd0};
        end
        if ((v[3:0] & DIGIT_MASK) == BCD_NINE) begin
            sum = sum + BCD_ADJUST;
        end
        sum = sum + 7'd1;
        return {1'b0, sum};
    endfunction

endpackage

`default_nettype wire

[rtl/bsw_if.sv]
// Channel interfaces of the BCD stopwatch: the command channel and the status
// channel, each with valid, ready and the item fields. No dependencies.
`default_nettype none

interface bsw_cmd_if;
    logic       valid;
    logic       ready;
    logic [2:0] op;
    logic [1:0] alarm_index;
    logic [6:0] alarm_minutes;
    logic [6:0] alarm_seconds;
    logic [3:0] alarm_tenths;

    modport source (
        output valid, op, alarm_index, alarm_minutes, alarm_seconds, alarm_tenths,
        input  ready
    );
    modport sink (
        input  valid, op, alarm_index, alarm_minutes, alarm_seconds, alarm_tenths,
        output ready
    );
endinterface

interface bsw_rsp_if;
    logic       valid;
    logic       ready;
    logic [6:0] now_minutes;
    logic [6:0] now_seconds;
    logic [3:0] now_tenths;
    logic       is_running;
    logic [3:0] ringing_mask;
    logic [3:0] enabled_mask;

    modport source (
        output valid, now_minutes, now_seconds, now_tenths, is_running,
               ringing_mask, enabled_mask,
        input  ready
    );
    modport sink (
        input  valid, now_minutes, now_seconds, now_tenths, is_running,
               ringing_mask, enabled_mask,
        output ready
    );
endinterface

`default_nettype wire

[rtl/bsw_clock.sv]
// Stopwatch time and run flag with the BCD tick increment.
// Depends on bsw_pkg.
`default_nettype none

module bsw_clock
    import bsw_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire logic  step,
    input  wire cmd_t  cmd,
    output time_t      now_time,
    output time_t      tick_time,
    output logic       running
);

    time_t time_reg;
    time_t time_next;
    logic  run_reg;
    logic  run_next;
    logic [7:0] sec_step;
    logic [7:0] min_step;

    // Time after one tick, used by the tick command and by the alarm compare.
    always_comb
    begin
        tick_time = time_reg;
        sec_step  = bcd2_step(time_reg.seconds);
        min_step  = bcd2_step(time_reg.minutes);
        if (run_reg)
        begin
            if (time_reg.tenths >= BCD_NINE)
            begin
                tick_time.tenths  = 4'd0;
                tick_time.seconds = sec_step[6:0];
                if (sec_step[7])
                begin
                    tick_time.minutes = min_step[6:0];
                end
            end
            else
            begin
                tick_time.tenths = time_reg.tenths + 4'd1;
            end
        end
    end

    always_comb
    begin
        time_next = time_reg;
        run_next  = run_reg;
        if (step)
        begin
            unique case (cmd.op)
                OP_TICK:       time_next = tick_time;
                OP_RESET_TIME: time_next = '0;
                OP_PAUSE:      run_next  = ~run_reg;
                default:       ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            time_reg <= '0;
            run_reg  <= 1'b1;
        end
        else
        begin
            time_reg <= time_next;
            run_reg  <= run_next;
        end
    end

    assign now_time = time_reg;
    assign running  = run_reg;

endmodule

`default_nettype wire

[rtl/bsw_alarms.sv]
// Alarm table: per-entry time, enable and ringing bits, with the parallel
// compare against the ticked time. Depends on bsw_pkg.
`default_nettype none

module bsw_alarms
    import bsw_pkg::*;
#(
    parameter int NUM_ALARMS = DEFAULT_NUM_ALARMS
)
(
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire logic                    step,
    input  wire cmd_t                    cmd,
    input  wire time_t                   tick_time,
    output logic [MASK_WIDTH-1:0]        ringing_mask,
    output logic [MASK_WIDTH-1:0]        enabled_mask
);

    time_t                 time_reg  [NUM_ALARMS];
    time_t                 time_next [NUM_ALARMS];
    logic [NUM_ALARMS-1:0] en_reg;
    logic [NUM_ALARMS-1:0] en_next;
    logic [NUM_ALARMS-1:0] ring_reg;
    logic [NUM_ALARMS-1:0] ring_next;

    // Each entry decides its own update; entries never interact.
    always_comb
    begin
        for (int i = 0; i < NUM_ALARMS; i++)
        begin
            time_next[i] = time_reg[i];
            en_next[i]   = en_reg[i];
            ring_next[i] = ring_reg[i];
            if (step)
            begin
                unique case (cmd.op)
                    OP_TICK:
                    begin
                        if (en_reg[i] && !ring_reg[i] && (time_reg[i] <= tick_time))
                        begin
                            ring_next[i] = 1'b1;
                        end
                    end
                    OP_EDIT:
                    begin
                        if (int'(cmd.index) == i)
                        begin
                            time_next[i] = cmd.alarm;
                            en_next[i]   = 1'b1;
                            ring_next[i] = 1'b0;
                        end
                    end
                    OP_ENABLE:
                    begin
                        if (int'(cmd.index) == i)
                        begin
                            en_next[i] = 1'b1;
                        end
                    end
                    OP_DISABLE:
                    begin
                        if (int'(cmd.index) == i)
                        begin
                            en_next[i] = 1'b0;
                        end
                    end
                    OP_STOP:
                    begin
                        if (ring_reg[i])
                        begin
                            ring_next[i] = 1'b0;
                            en_next[i]   = 1'b0;
                        end
                    end
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_ALARMS; i++)
            begin
                time_reg[i] <= '0;
            end
            en_reg   <= '0;
            ring_reg <= '0;
        end
        else
        begin
            for (int i = 0; i < NUM_ALARMS; i++)
            begin
                time_reg[i] <= time_next[i];
            end
            en_reg   <= en_next;
            ring_reg <= ring_next;
        end
    end

    // Only the first four entries are visible in the masks.
    for (genvar j = 0; j < MASK_WIDTH; j++)
    begin : g_mask
        if (j < NUM_ALARMS)
        begin : g_live
            assign ringing_mask[j] = ring_reg[j];
            assign enabled_mask[j] = en_reg[j];
        end
        else
        begin : g_absent
            assign ringing_mask[j] = 1'b0;
            assign enabled_mask[j] = 1'b0;
        end
    end

endmodule

`default_nettype wire

[rtl/bcd_stopwatch_with_alarms.sv]
// BCD stopwatch with alarm table, top level.
// Depends on bsw_pkg, bsw_if, bsw_clock and bsw_alarms.
//
// Usage:
//   Commands arrive on the cmd channel, one item per command: tick, reset
//   time, toggle pause, edit alarm, enable, disable or stop alarms. Every
//   command produces exactly one status item on the rsp channel that shows
//   the time, run flag and alarm masks after that command took effect.
//   A command item is captured in an input register. When it executes, the
//   BCD increment and the alarm compares run in one short combinational pass
//   and the stopwatch state registers update; those state registers are the
//   status payload, and the status valid flag is set at the same edge.
//   Throughput is one item per cycle as long as status items are taken.
//   Since state only changes when an item executes, a stalled status item
//   holds its values; the input register keeps one more command waiting,
//   and cmd.ready drops only while both a status item and a command wait.
//   Reset (rst_n low, asynchronous) clears the time, the alarm table and
//   both valid flags, and sets the stopwatch running. There is no clearing
//   pass: the block takes commands in the first cycle after reset.
`default_nettype none

module bcd_stopwatch_with_alarms
    import bsw_pkg::*;
#(
    parameter int NUM_ALARMS = DEFAULT_NUM_ALARMS
)
(
    input  wire logic clk,
    input  wire logic rst_n,
    bsw_cmd_if.sink   cmd,
    bsw_rsp_if.source rsp
);

    logic  in_valid_reg;
    logic  in_valid_next;
    cmd_t  cmd_reg;
    logic  out_valid_reg;
    logic  out_valid_next;
    logic  advance;
    logic  step;
    time_t now_time;
    time_t tick_time;
    logic  running;

    // The held command executes once the status slot is free or emptying.
    assign advance   = !out_valid_reg || rsp.ready;
    assign step      = in_valid_reg && advance;
    assign cmd.ready = !in_valid_reg || advance;

    always_comb
    begin
        in_valid_next  = cmd.ready ? cmd.valid : in_valid_reg;
        out_valid_next = step ? 1'b1 : (rsp.ready ? 1'b0 : out_valid_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Command payload needs no reset.
    always_ff @(posedge clk)
    begin
        if (cmd.valid && cmd.ready)
        begin
            cmd_reg.op            <= op_t'(cmd.op);
            cmd_reg.index         <= cmd.alarm_index;
            cmd_reg.alarm.minutes <= cmd.alarm_minutes;
            cmd_reg.alarm.seconds <= cmd.alarm_seconds;
            cmd_reg.alarm.tenths  <= cmd.alarm_tenths;
        end
    end

    bsw_clock u_clock (
        .clk       (clk),
        .rst_n     (rst_n),
        .step      (step),
        .cmd       (cmd_reg),
        .now_time  (now_time),
        .tick_time (tick_time),
        .running   (running)
    );

    bsw_alarms #(
        .NUM_ALARMS (NUM_ALARMS)
    ) u_alarms (
        .clk          (clk),
        .rst_n        (rst_n),
        .step         (step),
        .cmd          (cmd_reg),
        .tick_time    (tick_time),
        .ringing_mask (rsp.ringing_mask),
        .enabled_mask (rsp.enabled_mask)
    );

    assign rsp.valid       = out_valid_reg;
    assign rsp.now_minutes = now_time.minutes;
    assign rsp.now_seconds = now_time.seconds;
    assign rsp.now_tenths  = now_time.tenths;
    assign rsp.is_running  = running;

endmodule

`default_nettype wire

[rtl/bsw_checker.sv]
// Port-level checks for the BCD stopwatch, attached to the top level by bind.
// Depends on the top level's channel interfaces.
`default_nettype none

module bsw_checker (
    input wire logic       clk,
    input wire logic       rst_n,
    input wire logic       cmd_ready,
    input wire logic       rsp_valid,
    input wire logic       rsp_ready,
    input wire logic [6:0] now_minutes,
    input wire logic [6:0] now_seconds,
    input wire logic [3:0] now_tenths,
    input wire logic       is_running,
    input wire logic [3:0] ringing_mask,
    input wire logic [3:0] enabled_mask
);

    // A status item that is not taken keeps its values.
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(now_minutes)
            && $stable(now_seconds) && $stable(now_tenths) && $stable(is_running)
            && $stable(ringing_mask) && $stable(enabled_mask))
        else $error("status item changed while stalled");

    // The command side only backs up behind a stalled status item.
    a_ready_backpressure: assert property (@(posedge clk) disable iff (!rst_n)
        !cmd_ready |-> rsp_valid && !rsp_ready)
        else $error("command channel stalled without a stalled status item");

    // The tick counter never leaves the range zero to nine.
    a_tenths_range: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> now_tenths <= 4'd9)
        else $error("tenths digit out of range");

    // Seconds and minutes never pass 59.
    a_bcd_range: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> now_seconds <= 7'h59 && now_minutes <= 7'h59)
        else $error("seconds or minutes out of range");

endmodule

bind bcd_stopwatch_with_alarms bsw_checker u_bsw_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .cmd_ready    (cmd.ready),
    .rsp_valid    (rsp.valid),
    .rsp_ready    (rsp.ready),
    .now_minutes  (rsp.now_minutes),
    .now_seconds  (rsp.now_seconds),
    .now_tenths   (rsp.now_tenths),
    .is_running   (rsp.is_running),
    .ringing_mask (rsp.ringing_mask),
    .enabled_mask (rsp.enabled_mask)
);

`default_nettype wire

[test/tb_top.sv]
// Self-checking testbench for bcd_stopwatch_with_alarms: directed table, a minute of
// ticks and random command phases, scored against a cycle-free predictor of the block or typed-in expectations.
// Depends on rtl/bsw_pkg.sv, rtl/bsw_if.sv and the block's RTL.
`timescale 1ns / 1ps

module tb_top;
    import bsw_pkg::*;

    localparam int NUM_ALARMS = DEFAULT_NUM_ALARMS;

    // The one command code that the package leaves unnamed; the block must treat it
    // as a no-op that still reports its state.
    localparam logic [2:0] OP_UNUSED = 3'd7;

    // One status item's worth of fields, in the order the rsp channel carries them.
    typedef struct packed {
        time_t      now;
        logic       running;
        logic [3:0] ringing;
        logic [3:0] enabled;
    } status_t;

    // One row of the directed table. When has_lit is set the expected status is the
    // literal typed into the row; otherwise the predictor supplies it.
    typedef struct packed {
        logic [2:0] op;
        logic [1:0] idx;
        logic [6:0] al_min;
        logic [6:0] al_sec;
        logic [3:0] al_ten;
        logic       has_lit;
        logic [6:0] e_min;
        logic [6:0] e_sec;
        logic [3:0] e_ten;
        logic       e_run;
        logic [3:0] e_ring;
        logic [3:0] e_en;
    } dir_row_t;

    localparam int DIR_ROWS       = 23;
    localparam int MINUTE_TICKS   = 610;
    localparam int PHASE_ITEMS    = 230;
    localparam int SETTLE_CYCLES  = 4;
    localparam int TIMEOUT_NS     = 5_000_000;

    logic clk;
    logic rst_n;

    bsw_cmd_if cmd_ch ();
    bsw_rsp_if rsp_ch ();

    bcd_stopwatch_with_alarms #(
        .NUM_ALARMS (NUM_ALARMS)
    ) u_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd_ch.sink),
        .rsp   (rsp_ch.source)
    );

    // Clock: 10 ns period.
    initial begin
        clk = 1'b0;
    end

    always #5 clk = ~clk;

    // ------------------------------------------------------------------
    // Predictor state: the stopwatch time, the run flag and the alarm table,
    // as the block should hold them after every accepted command item.
    // ------------------------------------------------------------------
    time_t                 sw_now;
    logic                  sw_running;
    time_t                 alarm_at   [NUM_ALARMS];
    logic [NUM_ALARMS-1:0] alarm_on;
    logic [NUM_ALARMS-1:0] alarm_ring;

    // Expected status items, oldest first.
    status_t status_fifo [$];

    int mismatches;
    int cmds_accepted;
    int statuses_checked;
    int ticks_applied;
    int alarms_fired;

    // Knobs for the traffic shape: percent chance of a sender gap per cycle and of
    // the receiver holding ready low per cycle.
    int idle_pct;
    int stall_pct;

    // Side channel that rides along with the command item, so that the scoring block
    // knows whether the item carries a typed-in expectation.
    logic    drv_has_lit;
    status_t drv_lit;

    // Two-digit BCD increment that wraps to zero from 59 up. Anything at or above
    // 59 counts as the wrap point, so digits above nine never get stuck.
    function automatic logic [6:0] next_bcd2(input logic [6:0] v);
        if (v >= BCD_WRAP) begin
            return 7'd0;
        end
        if (v[3:0] == BCD_NINE) begin
            return v + BCD_ADJUST + 7'd1;
        end
        return v + 7'd1;
    endfunction

    // Applies one command to the predictor state and returns the status that the
    // block should report once the command has taken effect.
    function automatic status_t apply_cmd(input logic [2:0] op, input logic [1:0] idx,
                                          input time_t at);
        status_t st;
        case (op)
            OP_TICK:
            begin
                ticks_applied++;
                if (sw_running) begin
                    if (sw_now.tenths >= BCD_NINE) begin
                        sw_now.tenths = 4'd0;
                        // Minutes move only when the seconds wrap.
                        if (sw_now.seconds >= BCD_WRAP) begin
                            sw_now.minutes = next_bcd2(sw_now.minutes);
                        end
                        sw_now.seconds = next_bcd2(sw_now.seconds);
                    end
                    else begin
                        sw_now.tenths = sw_now.tenths + 4'd1;
                    end
                end
                // The alarm compare runs on every tick, paused or not, against the
                // whole packed time.
                for (int i = 0; i < NUM_ALARMS; i++) begin
                    if (alarm_on[i] && !alarm_ring[i] && alarm_at[i] <= sw_now) begin
                        alarm_ring[i] = 1'b1;
                        alarms_fired++;
                    end
                end
            end
            OP_RESET_TIME:
            begin
                sw_now = '0;
            end
            OP_PAUSE:
            begin
                sw_running = !sw_running;
            end
            OP_EDIT:
            begin
                if (idx < NUM_ALARMS) begin
                    alarm_at[idx]   = at;
                    alarm_on[idx]   = 1'b1;
                    alarm_ring[idx] = 1'b0;
                end
            end
            OP_ENABLE:
            begin
                if (idx < NUM_ALARMS) begin
                    alarm_on[idx] = 1'b1;
                end
            end
            OP_DISABLE:
            begin
                if (idx < NUM_ALARMS) begin
                    alarm_on[idx] = 1'b0;
                end
            end
            OP_STOP:
            begin
                // A ringing alarm is silenced and disarmed; quiet ones keep their enable.
                alarm_on   = alarm_on & ~alarm_ring;
                alarm_ring = '0;
            end
            default:
            begin
            end
        endcase
        st.now     = sw_now;
        st.running = sw_running;
        st.ringing = '0;
        st.enabled = '0;
        for (int i = 0; i < NUM_ALARMS && i < MASK_WIDTH; i++) begin
            st.ringing[i] = alarm_ring[i];
            st.enabled[i] = alarm_on[i];
        end
        return st;
    endfunction

    task automatic check_field(input string name, input logic [7:0] want_v,
                               input logic [7:0] got_v);
        if (want_v !== got_v) begin
            mismatches++;
            $display("%0t: %s expected %h got %h", $time, name, want_v, got_v);
        end
    endtask

    // ------------------------------------------------------------------
    // Scoring. Everything here samples at the rising edge, so it sees the values
    // that were present just before the edge, which is what the handshake uses.
    // The status check runs before the new expectation is queued: a status item
    // taken at this edge always belongs to an earlier command.
    // ------------------------------------------------------------------
    always @(posedge clk) begin
        status_t want;
        status_t got;
        if (rsp_ch.valid && rsp_ch.ready) begin
            got.now.minutes = rsp_ch.now_minutes;
            got.now.seconds = rsp_ch.now_seconds;
            got.now.tenths  = rsp_ch.now_tenths;
            got.running     = rsp_ch.is_running;
            got.ringing     = rsp_ch.ringing_mask;
            got.enabled     = rsp_ch.enabled_mask;
            if (status_fifo.size() == 0) begin
                mismatches++;
                $display("%0t: status item with nothing expected, got %h", $time, got);
            end
            else begin
                want = status_fifo.pop_front();
                statuses_checked++;
                check_field("now_minutes", want.now.minutes, got.now.minutes);
                check_field("now_seconds", want.now.seconds, got.now.seconds);
                check_field("now_tenths", want.now.tenths, got.now.tenths);
                check_field("is_running", want.running, got.running);
                check_field("ringing_mask", want.ringing, got.ringing);
                check_field("enabled_mask", want.enabled, got.enabled);
            end
        end
        if (cmd_ch.valid && cmd_ch.ready) begin
            cmds_accepted++;
            want = apply_cmd(cmd_ch.op, cmd_ch.alarm_index,
                             '{cmd_ch.alarm_minutes, cmd_ch.alarm_seconds,
                               cmd_ch.alarm_tenths});
            // A typed-in expectation stands in for the predictor's, which still had
            // to run so that its state keeps step with the block.
            if (drv_has_lit) begin
                want = drv_lit;
            end
            status_fifo.push_back(want);
        end
    end

    // Receiver: ready is redrawn on every edge according to the stall knob.
    always @(posedge clk) begin
        rsp_ch.ready <= ($urandom_range(99) >= stall_pct);
    end

    // ------------------------------------------------------------------
    // Sender. Gaps are drawn cycle by cycle before each item; valid is assigned
    // exactly once per edge, so back-to-back items never see a low-high glitch.
    // ------------------------------------------------------------------
    task automatic send_cmd(input logic [2:0] op, input logic [1:0] idx, input time_t at,
                            input logic lit_on, input status_t lit);
        while ($urandom_range(99) < idle_pct) begin
            cmd_ch.valid <= 1'b0;
            @(posedge clk);
        end
        cmd_ch.valid         <= 1'b1;
        cmd_ch.op            <= op;
        cmd_ch.alarm_index   <= idx;
        cmd_ch.alarm_minutes <= at.minutes;
        cmd_ch.alarm_seconds <= at.seconds;
        cmd_ch.alarm_tenths  <= at.tenths;
        drv_has_lit          <= lit_on;
        drv_lit              <= lit;
        @(posedge clk);
        while (!cmd_ch.ready) begin
            @(posedge clk);
        end
    endtask

    task automatic send_plain(input logic [2:0] op, input logic [1:0] idx, input time_t at);
        send_cmd(op, idx, at, 1'b0, '0);
    endtask

    // Waits until every expected status item has come back. The first edge lets the
    // expectation for the last accepted command land in the queue.
    task automatic drain_statuses();
        cmd_ch.valid <= 1'b0;
        @(posedge clk);
        while (status_fifo.size() != 0) begin
            @(posedge clk);
        end
    endtask

    // One random command. Most of the traffic is ticks, so that time moves on, and
    // edits that aim just ahead of the current time, so that alarms actually go off;
    // the rest covers every other code, full-range edits and the unused code.
    task automatic send_random_cmd();
        int    pick;
        logic [2:0] op;
        time_t at;
        pick = $urandom_range(99);
        at.minutes = 7'($urandom_range(127));
        at.seconds = 7'($urandom_range(127));
        at.tenths  = 4'($urandom_range(15));
        if (pick < 55) begin
            op = OP_TICK;
        end
        else if (pick < 70) begin
            op = OP_EDIT;
            if ($urandom_range(3) != 0) begin
                at.minutes = sw_now.minutes;
                at.seconds = $urandom_range(1) ? next_bcd2(sw_now.seconds) : sw_now.seconds;
                at.tenths  = 4'($urandom_range(9));
            end
        end
        else if (pick < 77) begin
            op = OP_ENABLE;
        end
        else if (pick < 84) begin
            op = OP_DISABLE;
        end
        else if (pick < 91) begin
            op = OP_STOP;
        end
        else if (pick < 95) begin
            op = OP_PAUSE;
        end
        else if (pick < 98) begin
            op = OP_RESET_TIME;
        end
        else begin
            op = OP_UNUSED;
        end
        send_plain(op, 2'($urandom_range(3)), at);
    endtask

    // Directed table. Rows with a literal follow a short, easy-to-trace story:
    // idle state after reset, the unused code with every field at its maximum,
    // an alarm at time zero going off, stop clearing both bits, an edit with every
    // field at its maximum, an alarm firing while paused, reset time keeping the run
    // flag, and an edit that silences a ringing alarm by rewriting it.
    dir_row_t dir_table [0:DIR_ROWS-1] = '{
        '{OP_UNUSED,     2'd3, 7'h7F, 7'h7F, 4'hF, 1'b1, 7'h00, 7'h00, 4'h0, 1'b1, 4'h0, 4'h0},
        '{OP_TICK,       2'd0, 7'h00, 7'h00, 4'h0, 1'b1, 7'h00, 7'h00, 4'h1, 1'b1, 4'h0, 4'h0},
        '{OP_EDIT,       2'd0, 7'h00, 7'h00, 4'h0, 1'b1, 7'h00, 7'h00, 4'h1, 1'b1, 4'h0, 4'h1},
        '{OP_TICK,       2'd0, 7'h00, 7'h00, 4'h0, 1'b1, 7'h00, 7'h00, 4'h2, 1'b1, 4'h1, 4'h1},
        '{OP_TICK,       2'd1, 7'h7F, 7'h00, 4'h0, 1'b0, 7'h00, 7'h00, 4'h0, 1'b0, 4'h0, 4'h0},
        '{OP_STOP,       2'd0, 7'h00, 7'h00, 4'h0, 1'b1, 7'h00, 7'h00, 4'h3, 1'b1, 4'h0, 4'h0},
        '{OP_EDIT,       2'd3, 7'h7F, 7'h7F, 4'hF, 1'b1, 7'h00, 7'h00, 4'h3, 1'b1, 4'h0, 4'h8},
        '{OP_ENABLE,     2'd2, 7'h00, 7'h00, 4'h0, 1'b1, 7'h00, 7'h00, 4'h3, 1'b1, 4'h0, 4'hC},
        '{OP_PAUSE,      2'd0, 7'h00, 7'h00, 4'h0, 1'b1, 7'h00, 7'h00, 4'h3, 1'b0, 4'h0, 4'hC},
        '{OP_TICK,       2'd0, 7'h00, 7'h00, 4'h0, 1'b1, 7'h00, 7'h00, 4'h3, 1'b0, 4'h4, 4'hC},
        '{OP_DISABLE,    2'd2, 7'h00, 7'h00, 4'h0, 1'b1, 7'h00, 7'h00, 4'h3, 1'b0, 4'h4, 4'h8},
        '{OP_STOP,       2'd0, 7'h00, 7'h00, 4'h0, 1'b1, 7'h00, 7'h00, 4'h3, 1'b0, 4'h0, 4'h8},
        '{OP_RESET_TIME, 2'd0, 7'h00, 7'h00, 4'h0, 1'b1, 7'h00, 7'h00, 4'h0, 1'b0, 4'h0, 4'h8},
        '{OP_PAUSE,      2'd0, 7'h00, 7'h00, 4'h0, 1'b1, 7'h00, 7'h00, 4'h0, 1'b1, 4'h0, 4'h8},
        '{OP_EDIT,       2'd1, 7'h00, 7'h00, 4'h2, 1'b0, 7'h00, 7'h00, 4'h0, 1'b0, 4'h0, 4'h0},
        '{OP_TICK,       2'd0, 7'h00, 7'h00, 4'h0, 1'b0, 7'h00, 7'h00, 4'h0, 1'b0, 4'h0, 4'h0},
        '{OP_TICK,       2'd0, 7'h00, 7'h00, 4'h0, 1'b0, 7'h00, 7'h00, 4'h0, 1'b0, 4'h0, 4'h0},
        '{OP_EDIT,       2'd1, 7'h00, 7'h00, 4'h2, 1'b1, 7'h00, 7'h00, 4'h2, 1'b1, 4'h0, 4'hA},
        '{OP_TICK,       2'd0, 7'h00, 7'h00, 4'h0, 1'b0, 7'h00, 7'h00, 4'h0, 1'b0, 4'h0, 4'h0},
        '{OP_DISABLE,    2'd1, 7'h00, 7'h00, 4'h0, 1'b0, 7'h00, 7'h00, 4'h0, 1'b0, 4'h0, 4'h0},
        '{OP_ENABLE,     2'd0, 7'h00, 7'h00, 4'h0, 1'b0, 7'h00, 7'h00, 4'h0, 1'b0, 4'h0, 4'h0},
        '{OP_TICK,       2'd0, 7'h00, 7'h00, 4'h0, 1'b0, 7'h00, 7'h00, 4'h0, 1'b0, 4'h0, 4'h0},
        '{OP_STOP,       2'd0, 7'h00, 7'h00, 4'h0, 1'b0, 7'h00, 7'h00, 4'h0, 1'b0, 4'h0, 4'h0}
    };

    // Traffic shape of the random phases: free-running, a sparse sender, a slow
    // receiver, and light idling on both sides.
    int phase_idle  [4] = '{0, 80, 0, 10};
    int phase_stall [4] = '{0, 0, 80, 10};

    initial begin
        time_t   at;
        status_t lit;

        // Everything the block reads has a known value from time zero on.
        rst_n                = 1'b0;
        cmd_ch.valid         = 1'b0;
        cmd_ch.op            = OP_TICK;
        cmd_ch.alarm_index   = 2'd0;
        cmd_ch.alarm_minutes = 7'd0;
        cmd_ch.alarm_seconds = 7'd0;
        cmd_ch.alarm_tenths  = 4'd0;
        rsp_ch.ready         = 1'b0;
        drv_has_lit          = 1'b0;
        drv_lit              = '0;
        idle_pct             = 0;
        stall_pct            = 0;
        mismatches           = 0;
        cmds_accepted        = 0;
        statuses_checked     = 0;
        ticks_applied        = 0;
        alarms_fired         = 0;

        // Predictor starts from the reset state: time zero, running, table cleared.
        sw_now     = '0;
        sw_running = 1'b1;
        alarm_on   = '0;
        alarm_ring = '0;
        for (int i = 0; i < NUM_ALARMS; i++) begin
            alarm_at[i] = '0;
        end

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        // Directed part. The block takes commands right after reset, so no settling
        // wait is needed.
        for (int r = 0; r < DIR_ROWS; r++) begin
            at  = '{dir_table[r].al_min, dir_table[r].al_sec, dir_table[r].al_ten};
            lit = '{'{dir_table[r].e_min, dir_table[r].e_sec, dir_table[r].e_ten},
                    dir_table[r].e_run, dir_table[r].e_ring, dir_table[r].e_en};
            send_cmd(dir_table[r].op, dir_table[r].idx, at, dir_table[r].has_lit, lit);
        end
        drain_statuses();

        // Just over a minute of ticks, so that tenths, seconds and the minute carry
        // all happen. Alarms sit at the last tenth of the first minute, at the start
        // of the second minute and at half a minute.
        if (!sw_running) begin
            send_plain(OP_PAUSE, 2'd0, '0);
        end
        send_plain(OP_EDIT, 2'd1, '{7'h01, 7'h00, 4'h0});
        send_plain(OP_EDIT, 2'd2, '{7'h00, 7'h30, 4'h0});
        send_plain(OP_EDIT, 2'd0, '{7'h00, 7'h59, 4'h9});
        send_plain(OP_RESET_TIME, 2'd0, '0);
        for (int n = 0; n < MINUTE_TICKS; n++) begin
            send_plain(OP_TICK, 2'($urandom_range(3)), '0);
        end
        send_plain(OP_STOP, 2'd0, '0);

        // Random phases. The sender holds off between phases until every expected
        // status item is back, which also leaves the block completely idle.
        for (int p = 0; p < 4; p++) begin
            drain_statuses();
            idle_pct  = phase_idle[p];
            stall_pct = phase_stall[p];
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                send_random_cmd();
            end
        end

        // Final drain, then a few more cycles in case a stray status item turns up.
        drain_statuses();
        stall_pct = 0;
        repeat (SETTLE_CYCLES) @(posedge clk);

        $display("Run covered %0d commands with %0d ticks, including a minute carry,",
                 cmds_accepted, ticks_applied);
        $display("%0d alarm triggers and %0d status items compared under four traffic shapes.",
                 alarms_fired, statuses_checked);
        if (mismatches == 0 && status_fifo.size() == 0) begin
            $display("SCOREBOARD CLEAN");
        end
        else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

    // Watchdog: well beyond the slowest legal run.
    initial begin
        #(TIMEOUT_NS);
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

[filelist.f]
rtl/bsw_pkg.sv
rtl/bsw_if.sv
rtl/bsw_clock.sv
rtl/bsw_alarms.sv
rtl/bcd_stopwatch_with_alarms.sv
rtl/bsw_checker.sv
test/tb_top.sv
